// ===== src/sem_pkg.sv =====
// Shared widths, codes, reset values and bundle types for the shutter edge exposure meter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sem_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = SAMPLE_W + 1;
  localparam int PERIOD_W = 16;
  localparam int SPREAD_W = 8;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 48;
  localparam int EMA_SHIFT = 6;
  localparam int EMA_W    = LEVEL_W + EMA_SHIFT;
  localparam int MIN_BAND = 8;
  localparam int BAND_SHIFT = 4;
  localparam int PROD_W   = SAMPLE_W + PERIOD_W;
  localparam int ITER_W   = $clog2(PERIOD_W);

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_RAIL   = 2'd1;
  localparam logic [1:0] REG_WEAK   = 2'd2;
  localparam logic [1:0] REG_SPREAD = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(2000);
  localparam logic [SAMPLE_W-1:0] RAIL_RST   = SAMPLE_W'(4063);
  localparam logic [SAMPLE_W-1:0] WEAK_RST   = SAMPLE_W'(48);
  localparam logic [SPREAD_W-1:0] SPREAD_RST = SPREAD_W'(16);

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WEAK    = 2'd1;
  localparam logic [1:0] ST_CLIPPED = 2'd2;
  localparam logic [1:0] ST_STALE   = 2'd3;

  // crossing job kinds
  localparam logic [1:0] JOB_RISE  = 2'd0;
  localparam logic [1:0] JOB_FALL  = 2'd1;
  localparam logic [1:0] JOB_STALE = 2'd2;

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SAMPLE_W-1:0] rail_level;
    logic [SAMPLE_W-1:0] weak_min_span;
    logic [SPREAD_W-1:0] initial_spread;
  } cfg_t;

  // one crossing handed from the classifier to the timing unit
  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          status;
    logic [SAMPLE_W-1:0] num;    // level minus lower endpoint
    logic [SAMPLE_W-1:0] den;    // upper minus lower endpoint
    logic [COUNT_W-1:0]  count;  // sample index of the crossing step
  } job_t;

endpackage

`default_nettype wire

// ===== src/sem_apb_regs.sv =====
// APB-style configuration registers of the exposure meter.
// Depends on sem_pkg for widths, register indexes and reset values.
`default_nettype none

module sem_apb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sem_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [sem_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output sem_pkg::cfg_t                       cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period         <= sem_pkg::PERIOD_RST;
      cfg.rail_level     <= sem_pkg::RAIL_RST;
      cfg.weak_min_span  <= sem_pkg::WEAK_RST;
      cfg.initial_spread <= sem_pkg::SPREAD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sem_pkg::REG_PERIOD: cfg.period <= pwdata[sem_pkg::PERIOD_W-1:0];
        sem_pkg::REG_RAIL:   cfg.rail_level <= pwdata[sem_pkg::SAMPLE_W-1:0];
        sem_pkg::REG_WEAK:   cfg.weak_min_span <= pwdata[sem_pkg::SAMPLE_W-1:0];
        sem_pkg::REG_SPREAD: cfg.initial_spread <= pwdata[sem_pkg::SPREAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sem_pkg::REG_PERIOD: prdata = sem_pkg::CFG_DATA_W'(cfg.period);
      sem_pkg::REG_RAIL:   prdata = sem_pkg::CFG_DATA_W'(cfg.rail_level);
      sem_pkg::REG_WEAK:   prdata = sem_pkg::CFG_DATA_W'(cfg.weak_min_span);
      sem_pkg::REG_SPREAD: prdata = sem_pkg::CFG_DATA_W'(cfg.initial_spread);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sem_front.sv =====
// Sample classifier: plateau tracking, hysteresis band, crossing detection, rail latch.
// Depends on sem_pkg; emits one crossing job per rise, fall or lone fall.
`default_nettype none

module sem_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  sem_pkg::cfg_t                     cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sem_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                         q_full,
  output logic                              job_push,
  output sem_pkg::job_t                     job
);

  localparam int LW = sem_pkg::LEVEL_W;
  localparam int SW = sem_pkg::SAMPLE_W;
  localparam int EW = sem_pkg::EMA_W;
  localparam int BW = LW - sem_pkg::BAND_SHIFT;
  localparam int CMP_W = LW + 2;

  logic                      seeded;
  logic [SW-1:0]             prev_sample;
  logic                      prev_in_band;
  logic [LW-1:0]             dark_level;
  logic [LW-1:0]             bright_level;
  logic                      pulse_open;
  logic [LW-1:0]             locked_threshold;
  logic                      rail_hit;
  logic [sem_pkg::COUNT_W-1:0] sample_count;

  logic                      accept;
  logic [LW:0]               lvl_sum;
  logic [LW-1:0]             thr;
  logic [LW-1:0]             span;
  logic [BW-1:0]             band;
  logic [BW-1:0]             band_m;
  logic [BW-2:0]             half;
  logic signed [CMP_W-1:0]   thr_s, low_s, high_s, prev_s, v_s;
  logic                      is_rise, is_fall, is_stale;
  logic                      rail_now;
  logic [EW-1:0]             dark_acc, bright_acc;
  logic [LW-1:0]             dark_ema, bright_ema;
  logic [1:0]                fall_status;

  assign in_ready = !q_full;
  assign accept   = in_valid & in_ready;

  assign lvl_sum = {1'b0, dark_level} + {1'b0, bright_level};
  assign thr     = lvl_sum[LW:1];
  assign span    = bright_level - dark_level;
  assign band    = span[LW-1:sem_pkg::BAND_SHIFT];
  assign band_m  = (band < BW'(sem_pkg::MIN_BAND)) ? BW'(sem_pkg::MIN_BAND) : band;
  assign half    = band_m[BW-1:1];

  assign thr_s  = $signed(CMP_W'(thr));
  assign low_s  = thr_s - $signed(CMP_W'(half));
  assign high_s = thr_s + $signed(CMP_W'(half));
  assign prev_s = $signed(CMP_W'(prev_sample));
  assign v_s    = $signed(CMP_W'(sample));

  // rise wins over any fall; a lone fall only counts with no pulse open
  assign is_rise  = (prev_s <= low_s) && (v_s >= thr_s);
  assign is_fall  = !is_rise && pulse_open && (LW'(prev_sample) >= locked_threshold)
                    && (LW'(sample) < locked_threshold);
  assign is_stale = !is_rise && !pulse_open && (prev_s >= high_s) && (v_s < thr_s);

  assign rail_now = rail_hit | (pulse_open & (sample >= cfg.rail_level));

  assign dark_acc   = (EW'(dark_level) << sem_pkg::EMA_SHIFT) - EW'(dark_level)
                      + EW'(prev_sample);
  assign bright_acc = (EW'(bright_level) << sem_pkg::EMA_SHIFT) - EW'(bright_level)
                      + EW'(prev_sample);
  assign dark_ema   = LW'(dark_acc >> sem_pkg::EMA_SHIFT);
  assign bright_ema = LW'(bright_acc >> sem_pkg::EMA_SHIFT);

  always_comb begin
    priority if (rail_now)                       fall_status = sem_pkg::ST_CLIPPED;
    else if (span < LW'(cfg.weak_min_span))      fall_status = sem_pkg::ST_WEAK;
    else                                         fall_status = sem_pkg::ST_OK;
  end

  always_comb begin
    job_push  = accept && seeded && (is_rise || is_fall || is_stale);
    job.count = sample_count;
    if (is_rise) begin
      job.kind   = sem_pkg::JOB_RISE;
      job.status = sem_pkg::ST_OK;
      job.num    = SW'(thr - LW'(prev_sample));
      job.den    = sample - prev_sample;
    end else if (is_fall) begin
      job.kind   = sem_pkg::JOB_FALL;
      job.status = fall_status;
      job.num    = SW'(locked_threshold - LW'(sample));
      job.den    = prev_sample - sample;
    end else begin
      job.kind   = sem_pkg::JOB_STALE;
      job.status = sem_pkg::ST_STALE;
      job.num    = '0;
      job.den    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded           <= 1'b0;
      prev_sample      <= '0;
      prev_in_band     <= 1'b0;
      dark_level       <= '0;
      bright_level     <= '0;
      pulse_open       <= 1'b0;
      locked_threshold <= '0;
      rail_hit         <= 1'b0;
      sample_count     <= '0;
    end else if (accept) begin
      prev_sample <= sample;
      if (!seeded) begin
        seeded       <= 1'b1;
        dark_level   <= LW'(sample);
        bright_level <= LW'(sample) + LW'(cfg.initial_spread);
        sample_count <= sem_pkg::COUNT_W'(1);
        prev_in_band <= 1'b0;
      end else begin
        prev_in_band <= (v_s >= low_s) && (v_s <= high_s);
        sample_count <= sample_count + 1'b1;
        rail_hit     <= is_rise ? 1'b0 : rail_now;
        if (is_rise) begin
          locked_threshold <= thr;
          pulse_open       <= 1'b1;
        end else if (is_fall) begin
          pulse_open <= 1'b0;
        end
        // plateaus learn only from out-of-band samples away from a crossing
        if (!prev_in_band && !is_rise && !is_fall && !is_stale) begin
          if (prev_s <= low_s) dark_level <= dark_ema;
          else if (prev_s >= high_s) bright_level <= bright_ema;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sem_job_queue.sv =====
// Short crossing-job queue between the classifier and the timing unit.
// Depends on sem_pkg for the job type and depth.
`default_nettype none

module sem_job_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  sem_pkg::job_t push_job,
  input  wire logic    pop,
  output sem_pkg::job_t head_job,
  output logic         full,
  output logic         empty
);

  sem_pkg::job_t                  slots [sem_pkg::JOB_DEPTH];
  logic [sem_pkg::JOB_PTR_W-1:0]  wr_ptr;
  logic [sem_pkg::JOB_PTR_W-1:0]  rd_ptr;
  logic [sem_pkg::JOB_PTR_W:0]    fill;

  assign full     = (fill == (sem_pkg::JOB_PTR_W+1)'(sem_pkg::JOB_DEPTH));
  assign empty    = (fill == '0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/sem_back.sv =====
// Crossing timing unit: base time multiply, serial restoring divide, result register.
// Depends on sem_pkg; holds the rise time between a rise job and its fall job.
`default_nettype none

module sem_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [sem_pkg::PERIOD_W-1:0] period,
  input  sem_pkg::job_t                     head_job,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [1:0]                   status,
  output logic      [sem_pkg::TIME_W-1:0]   exposure_ns
);

  localparam int PW = sem_pkg::PERIOD_W;
  localparam int SW = sem_pkg::SAMPLE_W;
  localparam int TW = sem_pkg::TIME_W;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_SUM  = 2'd3;

  logic [1:0]               state;
  sem_pkg::job_t            cur;
  logic [TW-1:0]            base_time;
  logic [SW-1:0]            rem;
  logic [PW-1:0]            quo;
  logic [sem_pkg::ITER_W-1:0] iter;
  logic                     den_zero;
  logic [TW-1:0]            rise_time;

  logic [sem_pkg::PROD_W-1:0] frac_prod;
  logic [TW-1:0]            count_prod;
  logic [SW:0]              trial;
  logic                     trial_ge;
  logic [TW-1:0]            cross_time;

  assign q_pop = (state == B_IDLE) && !q_empty && !out_valid;

  assign frac_prod  = sem_pkg::PROD_W'(cur.num) * sem_pkg::PROD_W'(period);
  assign count_prod = TW'(cur.count) * TW'(period);
  assign trial      = {rem, quo[PW-1]};
  assign trial_ge   = trial >= (SW+1)'(cur.den);
  assign cross_time = base_time + (den_zero ? '0 : TW'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      rise_time <= '0;
      iter      <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            cur <= head_job;
            if (head_job.kind == sem_pkg::JOB_STALE) begin
              out_valid   <= 1'b1;
              status      <= sem_pkg::ST_STALE;
              exposure_ns <= '0;
            end else begin
              state <= B_MUL;
            end
          end
        end
        B_MUL: begin
          // (n-1)*period taken as n*period - period keeps the wrap of a zero count
          base_time <= count_prod - TW'(period);
          rem       <= frac_prod[sem_pkg::PROD_W-1:PW];
          quo       <= frac_prod[PW-1:0];
          den_zero  <= (cur.den == '0);
          iter      <= sem_pkg::ITER_W'(PW - 1);
          state     <= B_DIV;
        end
        B_DIV: begin
          rem  <= trial_ge ? SW'(trial - (SW+1)'(cur.den)) : SW'(trial);
          quo  <= {quo[PW-2:0], trial_ge};
          iter <= iter - 1'b1;
          if (iter == '0) state <= B_SUM;
        end
        B_SUM: begin
          if (cur.kind == sem_pkg::JOB_RISE) begin
            rise_time <= cross_time;
          end else begin
            out_valid   <= 1'b1;
            status      <= cur.status;
            exposure_ns <= (cur.status == sem_pkg::ST_OK) ? cross_time - rise_time : '0;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/shutter_edge_exposure_meter.sv =====
// Shutter edge exposure meter top level. Samples are taken one per cycle while the
// two-entry crossing queue has room; a sample with no crossing yields nothing.
// A lone fall is queued, then goes straight to the result once the timing unit is idle
// with no result pending; rise and fall jobs pass the multiply, 16-step divide and sum.
// Synchronous reset returns registers to their reset values and clears plateaus and queue.
`default_nettype none

module shutter_edge_exposure_meter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sem_pkg::SAMPLE_W-1:0]   sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [1:0]                     status,
  output logic      [sem_pkg::TIME_W-1:0]     exposure_ns,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sem_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [sem_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  sem_pkg::cfg_t cfg;
  sem_pkg::job_t push_job;
  sem_pkg::job_t head_job;
  logic          job_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  sem_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sem_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (push_job)
  );

  sem_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sem_back u_back (
    .clk         (clk),
    .rst         (rst),
    .period      (cfg.period),
    .head_job    (head_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .exposure_ns (exposure_ns)
  );

  // a job leaves the queue only while no result beat is pending
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !out_valid)
    else $error("job popped while a result beat is pending");

  // only an ok pulse carries an exposure
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != sem_pkg::ST_OK) |-> (exposure_ns == '0))
    else $error("non-ok result with non-zero exposure");

  // a pushed job is never lost to an empty queue
  assert property (@(posedge clk) disable iff (rst)
    (job_push && !q_pop) |=> !q_empty)
    else $error("pushed job not held in queue");

endmodule

`default_nettype wire
